// ----- src/act_pkg.sv -----
// Package for the accelerometer tilt block: field widths, register codes,
// scaling constants and the CORDIC arctangent table. No dependencies.
`default_nettype none
package act_pkg;
	localparam int AXIS_W  = 16;
	localparam int CAL_W   = 18;
	localparam int OFF_W   = 12;
	localparam int ANGLE_W = 16;
	localparam int SQ_STEPS = 18;   // root bits of a 36 bit sum of squares
	localparam int CX_W    = 28;    // CORDIC x and y datapath width
	localparam int CZ_W    = 25;    // CORDIC angle accumulator width, Q.16 degrees

	localparam logic signed [CZ_W:0] DEG90_Q16  = 26'sd5898240;
	localparam logic signed [CZ_W:0] DEG180_Q16 = 26'sd11796480;

	// m = mg*512 + M_BIAS is floor((mg*4096 + 500 + Q_BIAS*1000) / 8) and is never negative.
	localparam logic signed [25:0] M_BIAS = 26'sd16777312;
	localparam logic [25:0]        RECIP_125 = 26'd34359739; // ceil(2^32/125)
	localparam logic signed [20:0] Q_BIAS = 21'sd134218;
	localparam logic signed [20:0] CAL_MAX = 21'sd131071;
	localparam logic signed [20:0] CAL_MIN = -21'sd131072;

	typedef enum logic [7:0] {
		REG_CAL_EN = 8'd0,
		REG_OFF_X  = 8'd1,
		REG_OFF_Y  = 8'd2,
		REG_OFF_Z  = 8'd3
	} reg_idx_t;

	// atan(2^-i) in degrees, Q.16.
	function automatic logic [22:0] atan_q16(input int i);
		logic [22:0] r;
		case (i)
			0: r = 23'd2949120;  1: r = 23'd1740967;  2: r = 23'd919879;
			3: r = 23'd466945;   4: r = 23'd234379;   5: r = 23'd117304;
			6: r = 23'd58666;    7: r = 23'd29335;    8: r = 23'd14668;
			9: r = 23'd7334;     10: r = 23'd3667;    11: r = 23'd1833;
			12: r = 23'd917;     13: r = 23'd458;     14: r = 23'd229;
			15: r = 23'd115;     16: r = 23'd57;      17: r = 23'd29;
			18: r = 23'd14;      19: r = 23'd7;       20: r = 23'd4;
			21: r = 23'd2;       22: r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- src/act_tilt.sv -----
// One tilt angle pipeline: sum of squares, bit-per-stage square root,
// unrolled CORDIC vectoring and final rounding. Uses act_pkg.
`default_nettype none
module act_tilt #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic signed [act_pkg::CAL_W-1:0] a,
	input  wire logic signed [act_pkg::CAL_W-1:0] b,
	input  wire logic signed [act_pkg::CAL_W-1:0] c,
	output logic [act_pkg::ANGLE_W-1:0]          angle
);
	localparam int SQ = act_pkg::SQ_STEPS;
	localparam int XW = act_pkg::CX_W;
	localparam int ZW = act_pkg::CZ_W;

	logic signed [35:0] bb, cc;
	logic [34:0] bb_s1, cc_s1;
	logic signed [act_pkg::CAL_W-1:0] a_s1, a_s2;
	logic [35:0] n_s2;

	assign bb = b * b;
	assign cc = c * c;

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= bb[34:0];
			cc_s1 <= cc[34:0];
			a_s1  <= a;
			n_s2  <= {1'b0, bb_s1} + {1'b0, cc_s1};
			a_s2  <= a_s1;
		end
	end

	// Square root, two radicand bits per stage.
	logic [19:0] rem_r [0:SQ];
	logic [17:0] root_r [0:SQ];
	logic [35:0] n_r [0:SQ];
	logic signed [act_pkg::CAL_W-1:0] a_r [0:SQ];

	assign rem_r[0]  = '0;
	assign root_r[0] = '0;
	assign n_r[0]    = n_s2;
	assign a_r[0]    = a_s2;

	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		logic [21:0] cur, trial;
		assign cur   = {rem_r[j], n_r[j][2*(SQ-1-j)+1 -: 2]};
		assign trial = {2'b00, root_r[j], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_r[j+1]  <= 20'(cur - trial);
					root_r[j+1] <= {root_r[j][16:0], 1'b1};
				end else begin
					rem_r[j+1]  <= cur[19:0];
					root_r[j+1] <= {root_r[j][16:0], 1'b0};
				end
				n_r[j+1] <= n_r[j];
				a_r[j+1] <= a_r[j];
			end
		end
	end

	// CORDIC vectoring; a stage with a zero residual passes its input on.
	logic signed [XW-1:0] cx [0:CORDIC_STAGES];
	logic signed [XW-1:0] cy [0:CORDIC_STAGES];
	logic signed [ZW-1:0] cz [0:CORDIC_STAGES];

	assign cx[0] = $signed({2'b00, root_r[SQ], 8'h00});
	assign cy[0] = $signed({{2{a_r[SQ][act_pkg::CAL_W-1]}}, a_r[SQ], 8'h00});
	assign cz[0] = '0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		logic signed [ZW-1:0] step;
		assign step = $signed({2'b00, act_pkg::atan_q16(i)});
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy[i] > 0) begin
					cx[i+1] <= cx[i] + (cy[i] >>> i);
					cy[i+1] <= cy[i] - (cx[i] >>> i);
					cz[i+1] <= cz[i] + step;
				end else if (cy[i] < 0) begin
					cx[i+1] <= cx[i] - (cy[i] >>> i);
					cy[i+1] <= cy[i] + (cx[i] >>> i);
					cz[i+1] <= cz[i] - step;
				end else begin
					cx[i+1] <= cx[i];
					cy[i+1] <= cy[i];
					cz[i+1] <= cz[i];
				end
			end
		end
	end

	logic signed [ZW:0] t_sum, t_clamp, t_rnd;
	always_comb begin
		t_sum = act_pkg::DEG90_Q16 + {cz[CORDIC_STAGES][ZW-1], cz[CORDIC_STAGES]};
		if (t_sum < 0)
			t_clamp = '0;
		else if (t_sum > act_pkg::DEG180_Q16)
			t_clamp = act_pkg::DEG180_Q16;
		else
			t_clamp = t_sum;
		t_rnd = (t_clamp + 26'sd128) >>> 8;
	end

	always_ff @(posedge clk) begin
		if (en)
			angle <= t_rnd[act_pkg::ANGLE_W-1:0];
	end
endmodule
`default_nettype wire

// ----- src/accel_calibrate_tilt_angles.sv -----
// Accelerometer calibration and tilt angles. The pipeline stages, in order, are
// three scaling stages, two sum-of-squares stages, 18 square root stages,
// one stage per CORDIC iteration and one rounding stage. A sample is taken every
// cycle; the whole pipeline holds while the output transfer is stalled.
// Reset clears the valid bits and loads the calibration registers with their defaults.
`default_nettype none
module accel_calibrate_tilt_angles #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// Fields from bit 0: accel_x[15:0], accel_y[31:16], accel_z[47:32].
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// Fields from bit 0: cal_x[17:0], cal_y[35:18], cal_z[53:36],
	// pitch_angle[69:54], roll_angle[85:70], zero fill [87:86].
	output logic [87:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	localparam int CW = act_pkg::CAL_W;
	localparam int TILT_LAT = 2 + act_pkg::SQ_STEPS + CORDIC_STAGES + 1;
	localparam int LAT = 3 + TILT_LAT;

	// Configuration registers; user writes only with the pipeline empty, unenforced.
	logic cal_en_q;
	logic signed [act_pkg::OFF_W-1:0] off_q [0:2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_en_q <= 1'b1;
			off_q[0] <= -12'sd49;
			off_q[1] <= 12'sd4;
			off_q[2] <= -12'sd86;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				act_pkg::REG_CAL_EN: cal_en_q <= cfg_data[0];
				act_pkg::REG_OFF_X:  off_q[0] <= $signed(cfg_data);
				act_pkg::REG_OFF_Y:  off_q[1] <= $signed(cfg_data);
				act_pkg::REG_OFF_Z:  off_q[2] <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// One enable moves every stage; a bubble at the output never blocks.
	logic adv;
	logic [LAT-1:0] vld_q;
	assign adv      = !vld_q[LAT-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	// Scaling: q = floor((mg*4096 + 500) / 1000), computed as a biased
	// divide by 8 and an exact reciprocal multiply for the divide by 125.
	logic signed [CW-1:0] cal_s3 [0:2];

	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [act_pkg::AXIS_W-1:0] mg;
		logic signed [25:0] m_full;
		logic [24:0] m_s1;
		logic signed [act_pkg::AXIS_W-1:0] raw_s1, raw_s2;
		logic [50:0] prod;
		logic [18:0] quot_s2;
		logic signed [20:0] q_sum;
		logic signed [CW-1:0] q_sat;

		assign mg     = $signed(s_tdata[16*k +: 16]);
		assign m_full = ({{10{mg[15]}}, mg} <<< 9) + act_pkg::M_BIAS;
		assign prod   = {26'd0, m_s1} * {25'd0, act_pkg::RECIP_125};

		always_comb begin
			q_sum = $signed({2'b00, quot_s2}) - act_pkg::Q_BIAS
				+ {{9{off_q[k][11]}}, off_q[k]};
			if (q_sum > act_pkg::CAL_MAX)
				q_sat = CW'(act_pkg::CAL_MAX);
			else if (q_sum < act_pkg::CAL_MIN)
				q_sat = CW'(act_pkg::CAL_MIN);
			else
				q_sat = q_sum[CW-1:0];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				m_s1    <= m_full[24:0];
				raw_s1  <= mg;
				quot_s2 <= prod[50:32];
				raw_s2  <= raw_s1;
				cal_s3[k] <= cal_en_q ? q_sat : {{2{raw_s2[15]}}, raw_s2};
			end
		end
	end

	// Pitch uses y against x and z; roll uses x against y and z.
	logic [act_pkg::ANGLE_W-1:0] pitch, roll;

	act_tilt #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(adv), .a(cal_s3[1]), .b(cal_s3[0]), .c(cal_s3[2]), .angle(pitch)
	);
	act_tilt #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(adv), .a(cal_s3[0]), .b(cal_s3[1]), .c(cal_s3[2]), .angle(roll)
	);

	// Calibrated axes ride along beside the angle pipelines.
	logic [3*CW-1:0] cal_dly [0:TILT_LAT-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			cal_dly[0] <= {cal_s3[2], cal_s3[1], cal_s3[0]};
			for (int d = 1; d < TILT_LAT; d++)
				cal_dly[d] <= cal_dly[d-1];
		end
	end

	assign m_tdata = {2'b00, roll, pitch, cal_dly[TILT_LAT-1]};

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without an output stall");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[69:54] <= 16'd46080))
		else $error("pitch out of range");
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[85:70] <= 16'd46080))
		else $error("roll out of range");
endmodule
`default_nettype wire
